// ===== rtl/pet_pkg.sv =====
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types, constants and helpers of the Prewitt edge threshold block.
// ----------------------------------------------------------------------------
package pet_pkg;

    // field widths
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int THR_W      = 11;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int POS_W      = 22;
    localparam int WH_W       = FW_W + FH_W;
    localparam int SUM_W      = 10;
    localparam int SQ_W       = 2 * SUM_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // sizing defaults
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MIN_DIM       = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    // register reset values and the products derived from them
    localparam logic [FW_W-1:0]     FW_RESET     = 11'd640;
    localparam logic [FH_W-1:0]     FH_RESET     = 12'd480;
    localparam logic [THR_W-1:0]    THR_RESET    = 11'd128;
    localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = 22'd16384;
    localparam logic [WH_W-1:0]     WH_RESET     = 23'd307200;

    // item codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // output levels
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    // luma weights, sum 256
    localparam logic [15:0] GRAY_WR = 16'd77;
    localparam logic [15:0] GRAY_WG = 16'd151;
    localparam logic [15:0] GRAY_WB = 16'd28;

    // one window column, top to bottom
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } pet_col_t;

    // status of the position divider
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [POS_W-1:0] quot;
        logic [FW_W-1:0]  rem;
    } pet_div_res_t;

    function automatic logic [PIX_W-1:0] gray_of(
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] b
    );
        logic [15:0] acc;
        acc = GRAY_WR * {8'b0, r} + GRAY_WG * {8'b0, g} + GRAY_WB * {8'b0, b};
        return acc[15:8];
    endfunction

    function automatic logic [SUM_W-1:0] absdiff(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        logic [SUM_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

// ===== rtl/pet_interfaces.sv =====
// ----------------------------------------------------------------------------
// pet interfaces
// Valid/ready channels for pixels in, results out and register writes.
// ----------------------------------------------------------------------------

// pixel or flush item
interface pet_pixel_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [pet_pkg::PIX_W-1:0]  pixel_red;
    logic [pet_pkg::PIX_W-1:0]  pixel_green;
    logic [pet_pkg::PIX_W-1:0]  pixel_blue;

    modport source (output valid, output op, output pixel_red, output pixel_green,
                    output pixel_blue, input ready);
    modport sink   (input valid, input op, input pixel_red, input pixel_green,
                    input pixel_blue, output ready);
endinterface

// result pixel
interface pet_result_if;
    logic                       valid;
    logic                       ready;
    logic [pet_pkg::PIX_W-1:0]  pixel_out;
    logic                       frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// register write
interface pet_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pet_pkg::CFG_IDX_W-1:0]   index;
    logic [pet_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pet_window_cell.sv =====
// ----------------------------------------------------------------------------
// pet_window_cell
// One column of the 3x3 window; takes its neighbour's column on each shift.
// ----------------------------------------------------------------------------
module pet_window_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  pet_pkg::pet_col_t             col_in,
    output pet_pkg::pet_col_t             col_out,
    output logic [pet_pkg::SUM_W-1:0]     col_sum
);

    pet_pkg::pet_col_t col_reg;

    // column storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    // column sum for the horizontal gradient
    assign col_sum = pet_pkg::SUM_W'(col_reg.top) + pet_pkg::SUM_W'(col_reg.mid)
                   + pet_pkg::SUM_W'(col_reg.bot);
    assign col_out = col_reg;

endmodule

// ===== rtl/pet_pos_divider.sv =====
// ----------------------------------------------------------------------------
// pet_pos_divider
// Restoring divider, one quotient bit a cycle: output position into
// row and column after a register write.
// ----------------------------------------------------------------------------
module pet_pos_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pet_pkg::POS_W-1:0]     dividend,
    input  logic [pet_pkg::FW_W-1:0]      divisor,
    output pet_pkg::pet_div_res_t         res
);

    localparam int CNT_W = $clog2(pet_pkg::POS_W + 1);

    logic [CNT_W-1:0]              count_reg;
    logic                          done_reg;
    logic [pet_pkg::POS_W-1:0]     quot_reg;
    logic [pet_pkg::FW_W-1:0]      rem_reg;
    logic [pet_pkg::FW_W-1:0]      divisor_reg;

    logic [pet_pkg::FW_W:0]        shifted;
    logic                          q_bit;
    logic [pet_pkg::FW_W-1:0]      rem_step;

    // one restoring step
    always_comb
    begin
        shifted  = {rem_reg, quot_reg[pet_pkg::POS_W-1]};
        q_bit    = shifted >= {1'b0, divisor_reg};
        rem_step = q_bit ? pet_pkg::FW_W'(shifted - {1'b0, divisor_reg})
                         : shifted[pet_pkg::FW_W-1:0];
    end

    // step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (count_reg == CNT_W'(1)) && !start;
            if (start)
            begin
                count_reg <= CNT_W'(pet_pkg::POS_W);
            end
            else if (count_reg != '0)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            quot_reg <= {quot_reg[pet_pkg::POS_W-2:0], q_bit};
            rem_reg  <= rem_step;
        end
    end

    assign res.busy = (count_reg != '0);
    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

// ===== rtl/prewitt_edge_threshold.sv =====
// ----------------------------------------------------------------------------
// prewitt_edge_threshold
// Gray conversion, 3x3 Prewitt gradient and threshold over a raster pixel
// stream. Pixels go in at one per clock and results come out at one per clock
// while result.ready is high and no recompute runs; the chain of three window
// cells and the single write and read of each line store per item set that
// figure. A result leaves frame_width+1 items after its pixel; the frame tail
// is drained with flush items, each giving one result. Interior pixels give
// 255 when gx^2+gy^2 < edge_threshold^2 and 0 otherwise; border pixels give
// their gray value. After every register write the block recomputes the
// output row and column from the output position with a bit-serial divider and
// holds pixel_in.ready low meanwhile. Line stores are not cleared at reset.
// ----------------------------------------------------------------------------
module prewitt_edge_threshold #(
    parameter int MAX_WIDTH = pet_pkg::MAX_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pet_cfg_if.sink      cfg,
    pet_pixel_if.sink    pixel_in,
    pet_result_if.source result
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = ((COL_W > pet_pkg::FW_W) ? COL_W : pet_pkg::FW_W) + 1;
    localparam int FWC_W = pet_pkg::FW_W + 1;

    // registers and derived values
    logic [pet_pkg::FW_W-1:0]     frame_width_reg;
    logic [pet_pkg::FH_W-1:0]     frame_height_reg;
    logic [pet_pkg::THR_W-1:0]    edge_threshold_reg;
    logic [pet_pkg::THR_SQ_W-1:0] thr_sq_reg;
    logic [pet_pkg::WH_W-1:0]     wh_reg;
    logic                         cfg_pending_reg;
    logic [pet_pkg::FW_W-1:0]     w_eff;
    logic [pet_pkg::FH_W-1:0]     h_eff;
    logic                         cfg_write;

    // counters
    logic [COL_W-1:0]             col_reg, col_next;
    logic [pet_pkg::FH_W-1:0]     row_reg, row_next;
    logic [pet_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [pet_pkg::FW_W-1:0]     ocol_reg, ocol_next;
    logic [pet_pkg::POS_W-1:0]    orow_reg, orow_next;

    // intake
    logic                         busy;
    logic                         accept;
    logic                         is_flush;
    logic                         draining;
    logic                         process;
    logic                         emit;
    logic                         wrap;
    logic                         last_now;
    logic                         border_now;
    logic [pet_pkg::PIX_W-1:0]    gray;

    // line stores
    logic [pet_pkg::PIX_W-1:0]    upper_mem  [MAX_WIDTH];
    logic [pet_pkg::PIX_W-1:0]    middle_mem [MAX_WIDTH];
    logic [pet_pkg::PIX_W-1:0]    upper_rd_reg;
    logic [pet_pkg::PIX_W-1:0]    middle_rd_reg;

    // window
    pet_pkg::pet_col_t            win_col [3];
    logic [pet_pkg::SUM_W-1:0]    win_sum [3];
    pet_pkg::pet_col_t            new_col;
    logic [pet_pkg::SUM_W-1:0]    top_sum;
    logic [pet_pkg::SUM_W-1:0]    bot_sum;

    // pipeline
    logic                         en2, en3, en4, en1;
    logic                         s1_valid_reg, s1_border_reg, s1_last_reg;
    logic                         s2_valid_reg, s2_border_reg, s2_last_reg;
    logic [pet_pkg::SUM_W-1:0]    s2_gx_reg, s2_gy_reg;
    logic [pet_pkg::PIX_W-1:0]    s2_center_reg;
    logic                         s3_valid_reg, s3_border_reg, s3_last_reg;
    logic [pet_pkg::SQ_W-1:0]     s3_gx2_reg, s3_gy2_reg;
    logic [pet_pkg::PIX_W-1:0]    s3_center_reg;
    logic [pet_pkg::THR_SQ_W-1:0] mag;
    logic                         out_valid_reg;
    logic [pet_pkg::PIX_W-1:0]    out_pixel_reg;
    logic                         out_last_reg;

    pet_pkg::pet_div_res_t        div_res;

    // register writes
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= pet_pkg::FW_RESET;
            frame_height_reg   <= pet_pkg::FH_RESET;
            edge_threshold_reg <= pet_pkg::THR_RESET;
            cfg_pending_reg    <= 1'b0;
        end
        else
        begin
            cfg_pending_reg <= cfg_write;
            if (cfg_write)
            begin
                case (cfg.index)
                    pet_pkg::REG_FRAME_WIDTH:
                        frame_width_reg <= cfg.data[pet_pkg::FW_W-1:0];
                    pet_pkg::REG_FRAME_HEIGHT:
                        frame_height_reg <= cfg.data[pet_pkg::FH_W-1:0];
                    pet_pkg::REG_EDGE_THRESHOLD:
                        edge_threshold_reg <= cfg.data[pet_pkg::THR_W-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // width and height saturated to the supported range
    always_comb
    begin
        if (frame_width_reg < pet_pkg::FW_W'(pet_pkg::MIN_DIM))
            w_eff = pet_pkg::FW_W'(pet_pkg::MIN_DIM);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            w_eff = pet_pkg::FW_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;

        if (frame_height_reg < pet_pkg::FH_W'(pet_pkg::MIN_DIM))
            h_eff = pet_pkg::FH_W'(pet_pkg::MIN_DIM);
        else
            h_eff = frame_height_reg;
    end

    // squared threshold and frame size, settled while the block is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_sq_reg <= pet_pkg::THR_SQ_RESET;
            wh_reg     <= pet_pkg::WH_RESET;
        end
        else
        begin
            thr_sq_reg <= pet_pkg::THR_SQ_W'(edge_threshold_reg)
                        * pet_pkg::THR_SQ_W'(edge_threshold_reg);
            wh_reg     <= pet_pkg::WH_W'(w_eff) * pet_pkg::WH_W'(h_eff);
        end
    end

    // output row and column recomputed after a register write
    pet_pos_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_pending_reg),
        .dividend (pos_reg),
        .divisor  (w_eff),
        .res      (div_res)
    );

    assign busy = cfg_pending_reg || div_res.busy || div_res.done;

    // pipeline stall chain
    assign en4 = !out_valid_reg || result.ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign pixel_in.ready = en1 && !busy;
    assign accept         = pixel_in.valid && pixel_in.ready;

    // intake decode
    always_comb
    begin
        is_flush = (pixel_in.op == pet_pkg::OP_FLUSH);
        draining = (row_reg >= h_eff);
        process  = accept && (is_flush == draining);
        gray     = is_flush ? '0 : pet_pkg::gray_of(pixel_in.pixel_red,
                                                    pixel_in.pixel_green,
                                                    pixel_in.pixel_blue);
        emit     = is_flush || (row_reg >= pet_pkg::FH_W'(2))
                 || ((row_reg == pet_pkg::FH_W'(1)) && (col_reg != '0));
        wrap     = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(w_eff);
        last_now = (pet_pkg::WH_W'(pos_reg) + pet_pkg::WH_W'(1)) >= wh_reg;
        border_now = (orow_reg == '0)
                   || ((pet_pkg::WH_W'(orow_reg) + pet_pkg::WH_W'(2))
                       > pet_pkg::WH_W'(h_eff))
                   || (ocol_reg == '0)
                   || ((FWC_W'(ocol_reg) + FWC_W'(2)) > FWC_W'(w_eff));
    end

    // counter update
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pos_next  = pos_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;

        if (process)
        begin
            if (wrap)
            begin
                col_next = '0;
                if (row_reg < h_eff)
                    row_next = row_reg + pet_pkg::FH_W'(1);
            end
            else
            begin
                col_next = COL_W'(CMP_W'(col_reg) + CMP_W'(1));
            end

            if (emit)
            begin
                if (last_now)
                begin
                    pos_next  = '0;
                    ocol_next = '0;
                    orow_next = '0;
                    col_next  = '0;
                    row_next  = '0;
                end
                else
                begin
                    pos_next = pos_reg + pet_pkg::POS_W'(1);
                    if ((FWC_W'(ocol_reg) + FWC_W'(1)) >= FWC_W'(w_eff))
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + pet_pkg::POS_W'(1);
                    end
                    else
                    begin
                        ocol_next = ocol_reg + pet_pkg::FW_W'(1);
                    end
                end
            end
        end

        if (div_res.done)
        begin
            ocol_next = div_res.rem;
            orow_next = div_res.quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pos_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pos_reg  <= pos_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
        end
    end

    // line stores: read ahead at the next column, forward a same-column write
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            upper_mem[col_reg]  <= middle_rd_reg;
            middle_mem[col_reg] <= gray;
        end
        if (process && (col_next == col_reg))
        begin
            upper_rd_reg  <= middle_rd_reg;
            middle_rd_reg <= gray;
        end
        else
        begin
            upper_rd_reg  <= upper_mem[col_next];
            middle_rd_reg <= middle_mem[col_next];
        end
    end

    // window: chain of three column cells, new column enters on the right
    assign new_col.top = upper_rd_reg;
    assign new_col.mid = middle_rd_reg;
    assign new_col.bot = gray;

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_cell
            if (gi == 2)
            begin : g_right
                pet_window_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (process),
                    .col_in   (new_col),
                    .col_out  (win_col[gi]),
                    .col_sum  (win_sum[gi])
                );
            end
            else
            begin : g_inner
                pet_window_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (process),
                    .col_in   (win_col[gi+1]),
                    .col_out  (win_col[gi]),
                    .col_sum  (win_sum[gi])
                );
            end
        end
    endgenerate

    // stage 1: window holds an item awaiting its decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (process && emit)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (en2)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && emit)
        begin
            s1_border_reg <= border_now;
            s1_last_reg   <= last_now;
        end
    end

    // stage 2: row and column differences
    always_comb
    begin
        top_sum = pet_pkg::SUM_W'(win_col[0].top) + pet_pkg::SUM_W'(win_col[1].top)
                + pet_pkg::SUM_W'(win_col[2].top);
        bot_sum = pet_pkg::SUM_W'(win_col[0].bot) + pet_pkg::SUM_W'(win_col[1].bot)
                + pet_pkg::SUM_W'(win_col[2].bot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_gx_reg     <= pet_pkg::absdiff(bot_sum, top_sum);
            s2_gy_reg     <= pet_pkg::absdiff(win_sum[2], win_sum[0]);
            s2_center_reg <= win_col[1].mid;
            s2_border_reg <= s1_border_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // stage 3: squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_gx2_reg    <= pet_pkg::SQ_W'(s2_gx_reg) * pet_pkg::SQ_W'(s2_gx_reg);
            s3_gy2_reg    <= pet_pkg::SQ_W'(s2_gy_reg) * pet_pkg::SQ_W'(s2_gy_reg);
            s3_center_reg <= s2_center_reg;
            s3_border_reg <= s2_border_reg;
            s3_last_reg   <= s2_last_reg;
        end
    end

    // stage 4: magnitude compare into the output register
    assign mag = pet_pkg::THR_SQ_W'(s3_gx2_reg) + pet_pkg::THR_SQ_W'(s3_gy2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en4)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            if (s3_border_reg)
                out_pixel_reg <= s3_center_reg;
            else if (mag < thr_sq_reg)
                out_pixel_reg <= pet_pkg::PIX_WHITE;
            else
                out_pixel_reg <= pet_pkg::PIX_BLACK;
            out_last_reg <= s3_last_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.pixel_out  = out_pixel_reg;
    assign result.frame_last = out_last_reg;

    // no transaction is taken while the output row and column are rebuilt
    a_no_accept_recalc: assert property (@(posedge clk) disable iff (!rst_n)
        (div_res.busy || div_res.done) |-> !accept)
        else $error("pixel transaction taken during position recalculation");

    // output column stays inside the frame width once settled
    a_ocol_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (ocol_reg < w_eff))
        else $error("output column beyond frame width");

    // the final result of a frame returns every counter to the frame start
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (process && emit && last_now) |=>
            (pos_reg == '0 && col_reg == '0 && row_reg == '0))
        else $error("counters not cleared after end of frame");

    // a waiting window decision is kept until stage 2 takes it
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en2) |=> (s1_valid_reg && $stable(s1_last_reg)))
        else $error("window decision lost while stalled");

endmodule

// ===== tb/sv/pet_edge_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pet_edge_checker
// Watches the register, pixel and result channels of prewitt_edge_threshold.
// Keeps its own copy of the registers, line stores and 3x3 window, predicts
// each result pixel and compares it with what the block returns, in order.
// ----------------------------------------------------------------------------
module pet_edge_checker #(
    parameter int MAX_WIDTH = pet_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pet_cfg_if          cfg,
    pet_pixel_if        pixel_in,
    pet_result_if       result,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned checked_count
);
    import pet_pkg::*;

    localparam int unsigned WIDTH_AT_RESET     = 640;
    localparam int unsigned HEIGHT_AT_RESET    = 480;
    localparam int unsigned THRESHOLD_AT_RESET = 128;
    localparam int unsigned POS_MASK           = 32'h003F_FFFF;
    localparam int unsigned LUMA_R             = 77;
    localparam int unsigned LUMA_G             = 151;
    localparam int unsigned LUMA_B             = 28;
    localparam int unsigned REPORT_LIMIT       = 20;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } edge_result_t;

    // register copies
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [THR_W-1:0] threshold_reg;

    // line stores, window and stream counters
    logic [PIX_W-1:0] row_two_up [MAX_WIDTH];
    logic [PIX_W-1:0] row_one_up [MAX_WIDTH];
    logic [PIX_W-1:0] window [9];
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      out_pos;

    edge_result_t     expected_pixels [$];
    int unsigned      fails;
    int unsigned      checked;

    // one accepted transaction through the gray, window and threshold stages
    function automatic void predict_edge_pixel(
        input logic             is_flush,
        input logic [PIX_W-1:0] red,
        input logic [PIX_W-1:0] green,
        input logic [PIX_W-1:0] blue
    );
        int unsigned      w;
        int unsigned      h;
        int unsigned      col_idx;
        int unsigned      orow;
        int unsigned      ocol;
        int unsigned      top_sum;
        int unsigned      bot_sum;
        int unsigned      left_sum;
        int unsigned      right_sum;
        int unsigned      gx;
        int unsigned      gy;
        int unsigned      mag;
        int unsigned      thr;
        logic [PIX_W-1:0] gray;
        logic             emit;
        edge_result_t     res;

        w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg < 3) ? 3 : height_reg;

        // flush only counts while draining, pixels only while receiving
        if (is_flush != (in_row >= h))
            return;

        gray = '0;
        emit = 1'b1;
        if (!is_flush)
        begin
            gray = PIX_W'((LUMA_R * red + LUMA_G * green + LUMA_B * blue) >> 8);
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        end

        // shift the window and roll the line stores
        col_idx = (in_col < MAX_WIDTH) ? in_col : 0;
        for (int r = 0; r < 3; r++)
        begin
            window[r * 3]     = window[r * 3 + 1];
            window[r * 3 + 1] = window[r * 3 + 2];
        end
        window[2] = row_two_up[col_idx];
        window[5] = row_one_up[col_idx];
        window[8] = gray;
        row_two_up[col_idx] = row_one_up[col_idx];
        row_one_up[col_idx] = gray;

        if (in_col + 1 >= w)
        begin
            in_col = 0;
            if (in_row < h)
                in_row++;
        end
        else
        begin
            in_col++;
        end

        if (!emit)
            return;

        // border keeps its gray value, interior gets the threshold decision
        orow = out_pos / w;
        ocol = out_pos % w;
        if (orow < 1 || orow + 2 > h || ocol < 1 || ocol + 2 > w)
        begin
            res.pixel_out = window[4];
        end
        else
        begin
            top_sum   = window[0] + window[1] + window[2];
            bot_sum   = window[6] + window[7] + window[8];
            left_sum  = window[0] + window[3] + window[6];
            right_sum = window[2] + window[5] + window[8];
            gx  = (bot_sum > top_sum) ? bot_sum - top_sum : top_sum - bot_sum;
            gy  = (right_sum > left_sum) ? right_sum - left_sum : left_sum - right_sum;
            mag = gx * gx + gy * gy;
            thr = threshold_reg;
            res.pixel_out = (mag < thr * thr) ? PIX_WHITE : PIX_BLACK;
        end

        res.frame_last = (out_pos + 1 >= w * h);
        if (res.frame_last)
        begin
            out_pos = 0;
            in_col  = 0;
            in_row  = 0;
        end
        else
        begin
            out_pos = (out_pos + 1) & POS_MASK;
        end
        expected_pixels.push_back(res);
    endfunction

    // compare results, track register writes, predict on every input transaction
    always @(posedge clk or negedge rst_n)
    begin
        edge_result_t want;

        if (!rst_n)
        begin
            width_reg     = FW_W'(WIDTH_AT_RESET);
            height_reg    = FH_W'(HEIGHT_AT_RESET);
            threshold_reg = THR_W'(THRESHOLD_AT_RESET);
            for (int k = 0; k < MAX_WIDTH; k++)
            begin
                row_two_up[k] = '0;
                row_one_up[k] = '0;
            end
            for (int k = 0; k < 9; k++)
                window[k] = '0;
            in_col  = 0;
            in_row  = 0;
            out_pos = 0;
            expected_pixels.delete();
            fails   = 0;
            checked = 0;
        end
        else
        begin
            // result side
            if (result.valid && result.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (fails < REPORT_LIMIT)
                        $error("unexpected result: pixel_out %0d frame_last %0b",
                               result.pixel_out, result.frame_last);
                    fails++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (result.pixel_out !== want.pixel_out)
                    begin
                        if (fails < REPORT_LIMIT)
                            $error("pixel_out: expected %0d, got %0d",
                                   want.pixel_out, result.pixel_out);
                        fails++;
                    end
                    if (result.frame_last !== want.frame_last)
                    begin
                        if (fails < REPORT_LIMIT)
                            $error("frame_last: expected %0b, got %0b",
                                   want.frame_last, result.frame_last);
                        fails++;
                    end
                end
            end

            // register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_FRAME_WIDTH:    width_reg     = cfg.data[FW_W-1:0];
                    REG_FRAME_HEIGHT:   height_reg    = cfg.data[FH_W-1:0];
                    REG_EDGE_THRESHOLD: threshold_reg = cfg.data[THR_W-1:0];
                    default:            ;
                endcase
            end

            // input side
            if (pixel_in.valid && pixel_in.ready)
                predict_edge_pixel(pixel_in.op == OP_FLUSH, pixel_in.pixel_red,
                                   pixel_in.pixel_green, pixel_in.pixel_blue);
        end

        fail_count    <= fails;
        pending       <= expected_pixels.size();
        checked_count <= checked;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for prewitt_edge_threshold. Sends whole frames of RGB
// pixels followed by their flush tail, with stray flush and pixel
// transactions mixed in, under changing frame sizes and thresholds and random
// idling on both channels; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb;
    import pet_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned TAIL_CALM    = 150;
    localparam int unsigned IDLE_TAIL    = 32;
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_FRAME   = 8;
    localparam int unsigned PAUSE_FRAME  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked_count;

    // stimulus bookkeeping
    int unsigned cur_w = 640;
    int unsigned cur_h = 480;
    int unsigned items_sent;
    int unsigned noise_sent;
    int unsigned frames_sent;
    int unsigned reg_writes;
    int unsigned widest;
    int unsigned tallest;
    int unsigned cycles;
    bit          calm;
    bit          tx_gappy;
    bit          hold_req;
    bit          hold_done;

    logic [23:0] directed_rgb [9] = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
                                      24'h00FF00, 24'h0000FF, 24'hFFFFFF,
                                      24'h000000, 24'h804020, 24'hFFFFFF};

    pet_pixel_if  pix_if ();
    pet_result_if res_if ();
    pet_cfg_if    cfg_if ();

    prewitt_edge_threshold dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_if),
        .pixel_in (pix_if),
        .result   (res_if)
    );

    pet_edge_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_if),
        .pixel_in      (pix_if),
        .result        (res_if),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one transaction on the pixel channel, returns after the handshake edge
    task automatic offer_item(input logic op, input logic [23:0] rgb);
        pix_if.valid       <= 1'b1;
        pix_if.op          <= op;
        pix_if.pixel_red   <= rgb[23:16];
        pix_if.pixel_green <= rgb[15:8];
        pix_if.pixel_blue  <= rgb[7:0];
        do @(posedge clk); while (!pix_if.ready);
    endtask

    // random sender idling
    task automatic take_gap();
        if (tx_gappy && !calm && $urandom_range(0, 3) == 0)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // block idle: nothing expected and the pipeline tail gone
    task automatic settle();
        wait_drained();
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        int unsigned raw;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
        // track the sizes the block will actually use
        if (idx == REG_FRAME_WIDTH)
        begin
            raw   = data & 12'h7FF;
            cur_w = (raw < 3) ? 3 : ((raw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : raw);
        end
        else if (idx == REG_FRAME_HEIGHT)
        begin
            cur_h = (data < 3) ? 3 : data;
        end
    endtask

    // a full frame plus its flush tail, with stray transactions the block ignores
    task automatic send_frame(input bit hold_here, input bit drain_pause);
        logic [7:0]  base;
        logic [7:0]  noise_mask;
        logic [7:0]  shade;
        logic [23:0] rgb;
        bit          split;

        base  = 8'($urandom);
        split = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
            0:       noise_mask = 8'h00;
            1:       noise_mask = 8'h03;
            2:       noise_mask = 8'h1F;
            default: noise_mask = 8'hFF;
        endcase
        if (cur_w > widest)
            widest = cur_w;
        if (cur_h > tallest)
            tallest = cur_h;

        for (int unsigned i = 0; i < cur_w * cur_h; i++)
        begin
            // flush before the frame is in: ignored
            if ($urandom_range(0, 15) == 0)
            begin
                offer_item(OP_FLUSH, 24'($urandom));
                noise_sent++;
            end
            rgb = '0;
            for (int k = 0; k < 3; k++)
            begin
                shade = (split && (i % cur_w) >= cur_w / 2) ? ~base : base;
                rgb   = {rgb[15:0], shade ^ (8'($urandom) & noise_mask)};
            end
            offer_item(OP_PIXEL, rgb);
            items_sent++;
            if (hold_here && i == 2)
                hold_req = 1'b1;
            if (drain_pause && i == cur_w * cur_h / 2)
                wait_drained();
            take_gap();
        end

        for (int unsigned j = 0; j <= cur_w; j++)
        begin
            // pixel while draining: ignored
            if ($urandom_range(0, 11) == 0)
            begin
                offer_item(OP_PIXEL, 24'($urandom));
                noise_sent++;
            end
            offer_item(OP_FLUSH, 24'($urandom));
            items_sent++;
            take_gap();
        end
        frames_sent++;
    endtask

    // result receiver, with one long hold-off to back the block up
    initial
    begin
        int unsigned n;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                res_if.ready <= 1'b0;
                n = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (calm)
            begin
                res_if.ready <= 1'b1;
                n = 16;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1:    begin res_if.ready <= 1'b0; n = $urandom_range(1, 19); end
                    2:       begin res_if.ready <= 1'b1; n = $urandom_range(100, 300); end
                    default: begin res_if.ready <= 1'b1; n = $urandom_range(1, 40); end
                endcase
            end
            // a hold-off request cuts the current burst short
            while (n > 0 && !(hold_req && !hold_done))
            begin
                @(posedge clk);
                n--;
            end
        end
    end

    // watchdog
    initial
    begin
        cycles = 0;
        do @(posedge clk); while (++cycles < CYCLE_LIMIT);
        $display("** prewitt_edge_threshold: FAILED **");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int unsigned frame_no;
        int unsigned small_items;
        int unsigned start_items;

        rst_n              <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= REG_FRAME_WIDTH;
        cfg_if.data        <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.op          <= OP_PIXEL;
        pix_if.pixel_red   <= '0;
        pix_if.pixel_green <= '0;
        pix_if.pixel_blue  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest frame, colour extremes, highest threshold,
        // a flush before the frame is in and a pixel during the drain
        calm = 1'b1;
        write_reg(REG_FRAME_WIDTH, 12'd3);
        write_reg(REG_FRAME_HEIGHT, 12'd3);
        write_reg(REG_EDGE_THRESHOLD, 12'h7FF);
        write_reg(REG_SPARE, 12'hFFF);
        offer_item(OP_FLUSH, 24'hFFFFFF);
        for (int k = 0; k < 9; k++)
            offer_item(OP_PIXEL, directed_rgb[k]);
        for (int k = 0; k < 4; k++)
        begin
            if (k == 1)
                offer_item(OP_PIXEL, 24'hFFFFFF);
            offer_item(OP_FLUSH, 24'h000000);
        end
        items_sent = 13;
        noise_sent = 2;
        frames_sent = 1;
        widest = 3;
        tallest = 3;

        // random frames, a few of them with register values beyond the field
        frame_no = 0;
        small_items = 0;
        while (small_items < RANDOM_ITEMS)
        begin
            settle();
            if (cur_w * cur_h > 100 || $urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 19))
                    0, 1:    write_reg(REG_FRAME_WIDTH, 12'($urandom_range(0, 2)));
                    2:       write_reg(REG_FRAME_WIDTH, 12'h800 | 12'($urandom_range(3, 9)));
                    default: write_reg(REG_FRAME_WIDTH, 12'($urandom_range(3, 10)));
                endcase
            end
            if (cur_h > 8 || $urandom_range(0, 1) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    write_reg(REG_FRAME_HEIGHT, 12'($urandom_range(0, 2)));
                else
                    write_reg(REG_FRAME_HEIGHT, 12'($urandom_range(3, 8)));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_EDGE_THRESHOLD, 12'($urandom));
            case (frame_no)
                1: write_reg(REG_EDGE_THRESHOLD, 12'h000);
                3:
                begin
                    write_reg(REG_FRAME_WIDTH, 12'h80A);
                    write_reg(REG_FRAME_HEIGHT, 12'd3);
                end
                4: write_reg(REG_EDGE_THRESHOLD, 12'hFFF);
                6:
                begin
                    write_reg(REG_FRAME_WIDTH, 12'h803);
                    write_reg(REG_FRAME_HEIGHT, 12'd8);
                end
                default: ;
            endcase

            calm = (small_items + TAIL_CALM >= RANDOM_ITEMS);
            tx_gappy = !calm && frame_no != HOLD_FRAME && $urandom_range(0, 2) != 0;
            start_items = items_sent;
            send_frame(frame_no == HOLD_FRAME, frame_no == PAUSE_FRAME);
            small_items += items_sent - start_items;
            frame_no++;
        end
        settle();

        $display("covered %0d frames, %0d pixel and flush transactions, %0d stray ones",
                 frames_sent, items_sent, noise_sent);
        $display("checked %0d result pixels; frames up to %0d wide and %0d tall, %0d reg writes",
                 checked_count, widest, tallest, reg_writes);
        if (fail_count == 0 && pending == 0)
            $display("** prewitt_edge_threshold: PASSED **");
        else
            $display("** prewitt_edge_threshold: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pet_pkg.sv
rtl/pet_interfaces.sv
rtl/pet_window_cell.sv
rtl/pet_pos_divider.sv
rtl/prewitt_edge_threshold.sv
tb/sv/pet_edge_checker.sv
tb/sv/tb.sv
